FILE: rtl/slcr_pkg.sv
// shared constants and types of the status led color renderer
`default_nettype none

package slcr_pkg;

	// block geometry
	localparam int LED_COUNT     = 6;
	localparam int STATE_COUNT   = 3;
	localparam int BLINK_HALF_MS = 500;

	// color table geometry, one entry per led and state
	localparam int TABLE_DEPTH = LED_COUNT * STATE_COUNT;
	localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// brightness percent scaling, division by the percent base via reciprocal
	localparam int PCT_MAX   = 100;
	localparam int PCT_ROUND = 50;
	localparam int PCT_SHIFT = 19;
	localparam int PCT_RECIP = ((2 ** PCT_SHIFT) + PCT_MAX - 1) / PCT_MAX;

	// blink phase, quotient estimate that is low by at most two
	localparam logic [31:0] BLINK_RECIP = 32'(64'hFFFF_FFFF / BLINK_HALF_MS);
	localparam logic [31:0] BLINK_DIV   = 32'(BLINK_HALF_MS);

	localparam logic [7:0] BRIGHT_RESET = 8'd100;
	localparam logic [2:0] LAST_LED     = 3'(LED_COUNT - 1);

	typedef logic [23:0] rgb_t;
	typedef logic [1:0]  led_state_t;

	// color channel being scaled
	typedef enum logic [1:0] {
		CH_GREEN = 2'd0,
		CH_RED   = 2'd1,
		CH_BLUE  = 2'd2
	} chan_t;

	// pick one byte out of an rgb word
	function automatic logic [7:0] rgb_chan(rgb_t c, chan_t ch);
		logic [7:0] v;
		case (ch)
			CH_GREEN: v = c[15:8];
			CH_RED:   v = c[23:16];
			CH_BLUE:  v = c[7:0];
			default:  v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/status_led_color_renderer.sv
// status led color renderer: color table, blink phase and brightness scaling
//
//  channel    | signals                                  | moves
//  -----------+------------------------------------------+-------------------------------
//  request    | req_valid / req_stall                    | func, now_ms, ledN_state, write
//  response   | rsp_valid / rsp_stall                    | led_index, green, red, blue, last
//  config     | cfg_wr_en / cfg_wr_data                  | brightness
//
// a write request updates the color table as it is taken; a render request runs
// in sequence on the single shared multiplier, lengthened by response stalls:
// two products for the blink phase, up to two correction steps, then two
// products per color channel, 36 for the six leds, one response per led.
// reset clears the color table to black and brightness to 100.
// the block holds req_stall high while a render request is in progress;
// a finished response waits in the output register while a new request is taken.
`default_nettype none

module status_led_color_renderer (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config
	input  wire logic                  cfg_wr_en,
	input  wire logic [7:0]            cfg_wr_data,
	// request
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire logic                  func,
	input  wire logic [31:0]           now_ms,
	input  wire logic [1:0]            led0_state,
	input  wire logic [1:0]            led1_state,
	input  wire logic [1:0]            led2_state,
	input  wire logic [1:0]            led3_state,
	input  wire logic [1:0]            led4_state,
	input  wire logic [1:0]            led5_state,
	input  wire logic [2:0]            write_led,
	input  wire logic [1:0]            write_state,
	input  wire logic [23:0]           write_color,
	// response
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output logic [2:0]                 led_index,
	output logic [7:0]                 green,
	output logic [7:0]                 red,
	output logic [7:0]                 blue,
	output logic                       last
);

	typedef logic [slcr_pkg::TBL_AW-1:0] tbl_idx_t;

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_BQ   = 10'b00_0000_0010,
		S_BR   = 10'b00_0000_0100,
		S_BSUB = 10'b00_0000_1000,
		S_BFIX = 10'b00_0001_0000,
		S_LOAD = 10'b00_0010_0000,
		S_SC1  = 10'b00_0100_0000,
		S_SC2  = 10'b00_1000_0000,
		S_SC3  = 10'b01_0000_0000,
		S_EMIT = 10'b10_0000_0000
	} state_t;

	state_t                 state_q;
	logic [7:0]             bright_q;
	logic [31:0]            now_q;
	slcr_pkg::led_state_t   states_q [6];
	slcr_pkg::rgb_t         color_q [slcr_pkg::TABLE_DEPTH];
	logic [2:0]             led_q;
	slcr_pkg::chan_t        ch_q;
	logic                   par_q;
	logic [31:0]            rem_q;
	slcr_pkg::rgb_t         col_q;
	logic [7:0]             res_g_q;
	logic [7:0]             res_r_q;
	logic [7:0]             res_b_q;
	logic [63:0]            prod_q;
	logic                   rsp_valid_q;
	logic [2:0]             rsp_led_q;
	logic [7:0]             rsp_g_q;
	logic [7:0]             rsp_r_q;
	logic [7:0]             rsp_b_q;
	logic                   rsp_last_q;

	logic                   req_fire;
	logic                   wr_ok;
	tbl_idx_t               wr_idx;
	slcr_pkg::led_state_t   st_raw;
	slcr_pkg::led_state_t   st_eff;
	tbl_idx_t               rd_idx;
	logic                   blackout;
	logic [6:0]             bright_c;
	logic [31:0]            mul_a;
	logic [31:0]            mul_b;
	logic [7:0]             scaled;
	logic                   rsp_free;
	logic                   emit_fire;

	// request handshake
	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;

	// table write address and range check
	assign wr_ok  = (write_led < 3'(slcr_pkg::LED_COUNT)) &&
	                ({1'b0, write_state} < 3'(slcr_pkg::STATE_COUNT));
	assign wr_idx = tbl_idx_t'(int'(write_led) * slcr_pkg::STATE_COUNT + int'(write_state));

	// table read for the current led, unknown states read the state zero entry
	assign st_raw   = states_q[led_q];
	assign st_eff   = ({1'b0, st_raw} >= 3'(slcr_pkg::STATE_COUNT)) ? '0 : st_raw;
	assign rd_idx   = tbl_idx_t'(int'(led_q) * slcr_pkg::STATE_COUNT + int'(st_eff));
	assign blackout = (led_q == 3'd0) && (st_eff != '0) && par_q;

	// brightness clamped to the percent base
	assign bright_c = (bright_q > 8'(slcr_pkg::PCT_MAX)) ? 7'(slcr_pkg::PCT_MAX) : bright_q[6:0];

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_BQ: begin
				mul_a = now_q;
				mul_b = slcr_pkg::BLINK_RECIP;
			end
			S_BR: begin
				mul_a = prod_q[63:32];
				mul_b = slcr_pkg::BLINK_DIV;
			end
			S_SC1: begin
				mul_a = {24'd0, slcr_pkg::rgb_chan(col_q, ch_q)};
				mul_b = {25'd0, bright_c};
			end
			S_SC2: begin
				mul_a = {17'd0, prod_q[14:0] + 15'(slcr_pkg::PCT_ROUND)};
				mul_b = 32'(slcr_pkg::PCT_RECIP);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// shared multiplier, product registered
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	assign scaled = prod_q[slcr_pkg::PCT_SHIFT +: 8];

	// response register handshake
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign emit_fire = (state_q == S_EMIT) && rsp_free;

	// brightness register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= slcr_pkg::BRIGHT_RESET;
		end else if (cfg_wr_en) begin
			bright_q <= cfg_wr_data;
		end
	end

	// color table, cleared to black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < slcr_pkg::TABLE_DEPTH; i++) begin
				color_q[i] <= '0;
			end
		end else if (req_fire && !func && wr_ok) begin
			color_q[wr_idx] <= write_color;
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (req_fire && func) begin
			now_q       <= now_ms;
			states_q[0] <= led0_state;
			states_q[1] <= led1_state;
			states_q[2] <= led2_state;
			states_q[3] <= led3_state;
			states_q[4] <= led4_state;
			states_q[5] <= led5_state;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			led_q   <= '0;
			ch_q    <= slcr_pkg::CH_GREEN;
			par_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire && func) begin
						state_q <= S_BQ;
					end
				end
				S_BQ: begin
					state_q <= S_BR;
				end
				S_BR: begin
					par_q   <= prod_q[32];
					state_q <= S_BSUB;
				end
				S_BSUB: begin
					state_q <= S_BFIX;
				end
				S_BFIX: begin
					if (rem_q >= slcr_pkg::BLINK_DIV) begin
						par_q <= ~par_q;
					end else begin
						led_q   <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					ch_q    <= slcr_pkg::CH_GREEN;
					state_q <= S_SC1;
				end
				S_SC1: begin
					state_q <= S_SC2;
				end
				S_SC2: begin
					state_q <= S_SC3;
				end
				S_SC3: begin
					case (ch_q)
						slcr_pkg::CH_GREEN: begin
							ch_q    <= slcr_pkg::CH_RED;
							state_q <= S_SC1;
						end
						slcr_pkg::CH_RED: begin
							ch_q    <= slcr_pkg::CH_BLUE;
							state_q <= S_SC1;
						end
						default: begin
							state_q <= S_EMIT;
						end
					endcase
				end
				S_EMIT: begin
					if (rsp_free) begin
						if (led_q == slcr_pkg::LAST_LED) begin
							state_q <= S_IDLE;
						end else begin
							led_q   <= led_q + 3'd1;
							state_q <= S_LOAD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// blink remainder, color word and channel results
	always_ff @(posedge clk) begin
		if (state_q == S_BSUB) begin
			rem_q <= now_q - prod_q[31:0];
		end else if ((state_q == S_BFIX) && (rem_q >= slcr_pkg::BLINK_DIV)) begin
			rem_q <= rem_q - slcr_pkg::BLINK_DIV;
		end
		if (state_q == S_LOAD) begin
			col_q <= blackout ? '0 : color_q[rd_idx];
		end
		if (state_q == S_SC3) begin
			case (ch_q)
				slcr_pkg::CH_GREEN: res_g_q <= scaled;
				slcr_pkg::CH_RED:   res_r_q <= scaled;
				default:            res_b_q <= scaled;
			endcase
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			rsp_led_q  <= led_q;
			rsp_g_q    <= res_g_q;
			rsp_r_q    <= res_r_q;
			rsp_b_q    <= res_b_q;
			rsp_last_q <= (led_q == slcr_pkg::LAST_LED);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign led_index = rsp_led_q;
	assign green     = rsp_g_q;
	assign red       = rsp_r_q;
	assign blue      = rsp_b_q;
	assign last      = rsp_last_q;

	// a render request starts the blink quotient
	a_render_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && func) |=> (state_q == S_BQ))
		else $error("render request did not start the sequencer");

	// the quotient estimate is low by at most two
	a_blink_fix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BFIX) |-> (rem_q < 32'(3 * slcr_pkg::BLINK_HALF_MS)))
		else $error("blink remainder out of correction range");

	// the scaled channel always fits a byte
	a_scaled_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SC3) |-> (prod_q[63:slcr_pkg::PCT_SHIFT + 8] == '0))
		else $error("scaled channel overflow");

	// last marks exactly the final led
	a_last_led: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (last == (led_index == slcr_pkg::LAST_LED)))
		else $error("last flag does not match led index");

endmodule

`default_nettype wire
